/* design/acm_pkg.sv */
// Shared types and constants for the multi-pattern matcher.
// No dependencies; every other design file imports this package.
package acm_pkg;

   localparam int CMD_W      = 2;
   localparam int SYM_W      = 8;
   localparam int NODE_OUT_W = 8;
   localparam int ENDS_W     = 8;

   localparam logic [ENDS_W-1:0] ENDS_MAX = '1;

   // Item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_PATTERN = 2'd0,
      CMD_BUILD   = 2'd1,
      CMD_TEXT    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   // Classified item as held in the queue between front and back
   typedef struct packed {
      cmd_type            cmd;
      logic [SYM_W-1:0]   symbol;
      logic               last;
   } item_type;

   // Back end status, seen by the top level
   typedef struct packed {
      logic clearing;
      logic idle;
   } back_status_type;

   // Back end sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CHK,
      ST_END_RD,
      ST_END_UPD,
      ST_ADV_RD,
      ST_ADV_CHK,
      ST_ADV_LINK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_POP_RD,
      ST_POP_CHK,
      ST_PAR_CHK,
      ST_SL_RD,
      ST_RESULT
   } state_type;

endpackage

/* design/acm_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on acm_pkg for field widths.
interface acm_req_if import acm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [SYM_W-1:0]   symbol;
   logic               last;

   modport source (output valid, output cmd, output symbol, output last, input ready);
   modport sink   (input valid, input cmd, input symbol, input last, output ready);
endinterface

interface acm_rsp_if import acm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [NODE_OUT_W-1:0]   node;
   logic [ENDS_W-1:0]       pattern_ends;
   logic                    table_full;

   modport source (output valid, output node, output pattern_ends, output table_full,
                   input ready);
   modport sink   (input valid, input node, input pattern_ends, input table_full,
                   output ready);
endinterface

/* design/aho_corasick_matcher.sv */
// Top level of the multi-pattern matcher: front queue and back sequencer.
// Depends on acm_pkg, acm_if, acm_front, acm_back.
//
//   channel | direction | fields                         | handshake
//   req     | in        | cmd[1:0] symbol[7:0] last      | valid/ready
//   rsp     | out       | node[7:0] pattern_ends[7:0]    | valid/ready
//           |           | table_full                     |
//
// One response per request transaction, in order. The back sequencer works on
// one item at a time through its tables: a pattern byte looks up or allocates
// its edge, a text byte follows suffix links on a missing edge; a build scans
// the children of each node (root included) into a queue, and for a queued node
// below the first level walks the suffix links from its parent's link.
// After reset the child table is cleared, during which requests queue but
// none is started.
// A two-entry queue takes requests while the back works; a stalled response
// holds the back in its result step.
module aho_corasick_matcher import acm_pkg::*; #(
   parameter int MAX_NODES = 256,
   parameter int ALPHABET  = 256
) (
   input  logic        clock,
   input  logic        reset,
   acm_req_if.sink     req,
   acm_rsp_if.source   rsp
);

   item_type         item;
   logic             item_valid;
   logic             item_pop;
   back_status_type  status;

   acm_front #(
      .ALPHABET (ALPHABET)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   acm_back #(
      .MAX_NODES (MAX_NODES),
      .ALPHABET  (ALPHABET)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .status     (status),
      .rsp        (rsp)
   );

   // No item leaves the queue while the child table is being cleared
   assert property (@(posedge clock) disable iff (reset) status.clearing |-> !item_pop)
      else $error("item taken during table clear");

   // Items are only taken by an idle sequencer, and only when present
   assert property (@(posedge clock) disable iff (reset)
                    item_pop |-> (status.idle && item_valid))
      else $error("item taken while busy or queue empty");

   // No response in the cycle after a reset edge
   assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid after reset");

endmodule

/* design/acm_front.sv */
// Front end: takes request transactions, reduces the symbol to the alphabet
// and holds classified items in a two-entry queue. Depends on acm_pkg, acm_if.
module acm_front import acm_pkg::*; #(
   parameter int ALPHABET = 256
) (
   input  logic       clock,
   input  logic       reset,
   acm_req_if.sink    req,
   output item_type   item,
   output logic       item_valid,
   input  logic       item_pop
);

   typedef logic [SYM_W-1:0] sym_tab_type [256];

   // Symbol modulo alphabet, worked out at elaboration
   function automatic sym_tab_type mod_table();
      sym_tab_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = SYM_W'(i % ALPHABET);
      end
      return t;
   endfunction

   localparam sym_tab_type SYM_MOD = mod_table();

   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   item_type    in_item;
   logic        push, pop;

   // Classify the incoming transaction
   always_comb begin
      in_item.cmd    = cmd_type'(req.cmd);
      in_item.symbol = SYM_MOD[req.symbol];
      in_item.last   = req.last;
   end

   assign req.ready  = (count_ff < 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req.valid && req.ready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // Queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

/* design/acm_back.sv */
// Back end: trie tables and the sequencer that inserts, builds suffix links,
// steps the text state, plus the response register. Depends on acm_pkg, acm_if.
module acm_back import acm_pkg::*; #(
   parameter int MAX_NODES = 256,
   parameter int ALPHABET  = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  item_type         item,
   input  logic             item_valid,
   output logic             item_pop,
   output back_status_type  status,
   acm_rsp_if.source        rsp
);

   localparam int NW     = $clog2(MAX_NODES);
   localparam int SW     = $clog2(ALPHABET);
   localparam int CW     = NW + SW;
   localparam int CDEPTH = 1 << CW;

   localparam logic [NW:0]   NODE_LIMIT = (NW+1)'(MAX_NODES);
   localparam logic [SW-1:0] SYM_LAST   = SW'(ALPHABET - 1);

   // Tables
   logic [NW-1:0]     child_mem  [CDEPTH];
   logic [NW-1:0]     link_mem   [MAX_NODES];
   logic [NW-1:0]     parent_mem [MAX_NODES];
   logic [ENDS_W-1:0] ends_mem   [MAX_NODES];
   logic [CW-1:0]     queue_mem  [MAX_NODES];

   logic [NW-1:0]     child_q, link_q, parent_q;
   logic [ENDS_W-1:0] ends_q;
   logic [CW-1:0]     queue_q;
   logic              ends_zero_ff;

   // Table port controls
   logic              child_we;
   logic [CW-1:0]     child_waddr, child_raddr;
   logic [NW-1:0]     child_wdata;
   logic              link_we;
   logic [NW-1:0]     link_waddr, link_wdata, link_raddr;
   logic              parent_we;
   logic [NW-1:0]     parent_waddr, parent_wdata, parent_raddr;
   logic              ends_we;
   logic [NW-1:0]     ends_waddr, ends_raddr;
   logic [ENDS_W-1:0] ends_wdata;
   logic              queue_we;
   logic [NW-1:0]     queue_waddr, queue_raddr;
   logic [CW-1:0]     queue_wdata;

   // Sequencer registers
   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [SW-1:0]     sym_ff, sym_in;
   logic              last_ff, last_in;
   logic [NW-1:0]     cursor_ff, cursor_in;
   logic [NW-1:0]     text_ff, text_in;
   logic [NW-1:0]     work_ff, work_in;
   logic              full_ff, full_in;
   logic [NW-1:0]     adv_ff, adv_in;
   logic [SW-1:0]     adv_sym_ff, adv_sym_in;
   logic [NW:0]       guard_ff, guard_in;
   logic [NW-1:0]     cur_ff, cur_in;
   logic [NW-1:0]     scan_node_ff, scan_node_in;
   logic [SW-1:0]     scan_ff, scan_in;
   logic [NW:0]       head_ff, head_in;
   logic [NW:0]       tail_ff, tail_in;
   logic [NW:0]       count_ff, count_in;
   logic [CW-1:0]     clr_ff, clr_in;
   logic [NW-1:0]     res_node_ff, res_node_in;
   logic [ENDS_W-1:0] res_ends_ff, res_ends_in;
   logic              res_full_ff, res_full_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_OUT_W-1:0] rsp_node_ff;
   logic [ENDS_W-1:0] rsp_ends_ff;
   logic              rsp_full_ff;
   logic              load_out;

   logic              adv_fin;
   logic [NW-1:0]     adv_res;
   logic [ENDS_W-1:0] ends_val, ends_inc;
   logic [NW-1:0]     alloc_node;

   assign ends_val   = ends_zero_ff ? '0 : ends_q;
   assign ends_inc   = (ends_val == ENDS_MAX) ? ENDS_MAX : ends_val + 1'b1;
   assign alloc_node = count_ff[NW-1:0];

   // Next state, table controls and results
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      cursor_in    = cursor_ff;
      text_in      = text_ff;
      work_in      = work_ff;
      full_in      = full_ff;
      adv_in       = adv_ff;
      adv_sym_in   = adv_sym_ff;
      guard_in     = guard_ff;
      cur_in       = cur_ff;
      scan_node_in = scan_node_ff;
      scan_in      = scan_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      res_node_in  = res_node_ff;
      res_ends_in  = res_ends_ff;
      res_full_in  = res_full_ff;
      item_pop     = 1'b0;
      load_out     = 1'b0;
      adv_fin      = 1'b0;
      adv_res      = adv_ff;

      child_we     = 1'b0;
      child_waddr  = '0;
      child_wdata  = '0;
      child_raddr  = '0;
      link_we      = 1'b0;
      link_waddr   = '0;
      link_wdata   = '0;
      link_raddr   = '0;
      parent_we    = 1'b0;
      parent_waddr = '0;
      parent_wdata = '0;
      parent_raddr = '0;
      ends_we      = 1'b0;
      ends_waddr   = '0;
      ends_wdata   = '0;
      ends_raddr   = '0;
      queue_we     = 1'b0;
      queue_waddr  = '0;
      queue_wdata  = '0;
      queue_raddr  = '0;

      case (state_ff)
         // Clearing pass over the child table
         ST_CLEAR: begin
            child_we    = 1'b1;
            child_waddr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            item_pop = item_valid;
            if (item_valid) begin
               cmd_in  = item.cmd;
               sym_in  = item.symbol[SW-1:0];
               last_in = item.last;
               case (item.cmd)
                  CMD_PATTERN: state_in = ST_INS_RD;
                  CMD_BUILD: begin
                     head_in      = '0;
                     tail_in      = '0;
                     scan_node_in = '0;
                     scan_in      = '0;
                     state_in     = ST_SCAN_RD;
                  end
                  CMD_TEXT: begin
                     adv_in     = text_ff;
                     adv_sym_in = item.symbol[SW-1:0];
                     guard_in   = '0;
                     state_in   = ST_ADV_RD;
                  end
                  CMD_RESTART: begin
                     text_in  = '0;
                     work_in  = '0;
                     full_in  = 1'b0;
                     state_in = ST_END_RD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         // Insertion: look up the edge, allocate a node if needed
         ST_INS_RD: begin
            child_raddr = {cursor_ff, sym_ff};
            state_in    = ST_INS_CHK;
         end
         ST_INS_CHK: begin
            full_in = 1'b0;
            if (child_q != '0) begin
               work_in = child_q;
            end else if (count_ff < NODE_LIMIT) begin
               child_we     = 1'b1;
               child_waddr  = {cursor_ff, sym_ff};
               child_wdata  = alloc_node;
               parent_we    = 1'b1;
               parent_waddr = alloc_node;
               parent_wdata = cursor_ff;
               link_we      = 1'b1;
               link_waddr   = alloc_node;
               ends_we      = 1'b1;
               ends_waddr   = alloc_node;
               count_in     = count_ff + 1'b1;
               work_in      = alloc_node;
            end else begin
               full_in = 1'b1;
               work_in = cursor_ff;
            end
            state_in = ST_END_RD;
         end
         // End count of the result node, raised when a pattern closes
         ST_END_RD: begin
            ends_raddr = work_ff;
            state_in   = ST_END_UPD;
         end
         ST_END_UPD: begin
            res_node_in = work_ff;
            res_full_in = full_ff;
            res_ends_in = ends_val;
            if (cmd_ff == CMD_PATTERN) begin
               cursor_in = last_ff ? '0 : work_ff;
               if (last_ff && !full_ff) begin
                  ends_we     = 1'b1;
                  ends_waddr  = work_ff;
                  ends_wdata  = ends_inc;
                  res_ends_in = ends_inc;
               end
            end
            state_in = ST_RESULT;
         end
         // Goto with suffix link fallback
         ST_ADV_RD: begin
            child_raddr = {adv_ff, adv_sym_ff};
            state_in    = ST_ADV_CHK;
         end
         ST_ADV_CHK: begin
            if (child_q != '0) begin
               adv_fin = 1'b1;
               adv_res = child_q;
            end else if (adv_ff == '0 || guard_ff == NODE_LIMIT) begin
               adv_fin = 1'b1;
            end else begin
               link_raddr = adv_ff;
               state_in   = ST_ADV_LINK;
            end
         end
         ST_ADV_LINK: begin
            adv_in   = link_q;
            guard_in = guard_ff + 1'b1;
            state_in = ST_ADV_RD;
         end
         // Breadth-first build: scan a node's children into the queue
         ST_SCAN_RD: begin
            child_raddr = {scan_node_ff, scan_ff};
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (child_q != '0 && tail_ff < NODE_LIMIT) begin
               queue_we    = 1'b1;
               queue_waddr = tail_ff[NW-1:0];
               queue_wdata = {child_q, scan_ff};
               tail_in     = tail_ff + 1'b1;
            end
            scan_in  = scan_ff + 1'b1;
            state_in = (scan_ff == SYM_LAST) ? ST_POP_RD : ST_SCAN_RD;
         end
         ST_POP_RD: begin
            if (head_ff == tail_ff) begin
               res_node_in = '0;
               res_ends_in = '0;
               res_full_in = 1'b0;
               state_in    = ST_RESULT;
            end else begin
               queue_raddr = head_ff[NW-1:0];
               state_in    = ST_POP_CHK;
            end
         end
         ST_POP_CHK: begin
            cur_in       = queue_q[CW-1:SW];
            adv_sym_in   = queue_q[SW-1:0];
            head_in      = head_ff + 1'b1;
            parent_raddr = queue_q[CW-1:SW];
            state_in     = ST_PAR_CHK;
         end
         ST_PAR_CHK: begin
            if (parent_q != '0) begin
               link_raddr = parent_q;
               state_in   = ST_SL_RD;
            end else begin
               link_we      = 1'b1;
               link_waddr   = cur_ff;
               scan_node_in = cur_ff;
               scan_in      = '0;
               state_in     = ST_SCAN_RD;
            end
         end
         ST_SL_RD: begin
            adv_in   = link_q;
            guard_in = '0;
            state_in = ST_ADV_RD;
         end
         // Hand the result to the response register
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Fallback walk finished: text step or link of the current build node
      if (adv_fin) begin
         if (cmd_ff == CMD_TEXT) begin
            text_in  = adv_res;
            work_in  = adv_res;
            full_in  = 1'b0;
            state_in = ST_END_RD;
         end else begin
            link_we      = 1'b1;
            link_waddr   = cur_ff;
            link_wdata   = adv_res;
            scan_node_in = cur_ff;
            scan_in      = '0;
            state_in     = ST_SCAN_RD;
         end
      end
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= (NW+1)'(1);
         cursor_ff    <= '0;
         text_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         text_ff      <= text_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      sym_ff       <= sym_in;
      last_ff      <= last_in;
      work_ff      <= work_in;
      full_ff      <= full_in;
      adv_ff       <= adv_in;
      adv_sym_ff   <= adv_sym_in;
      guard_ff     <= guard_in;
      cur_ff       <= cur_in;
      scan_node_ff <= scan_node_in;
      scan_ff      <= scan_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      res_node_ff  <= res_node_in;
      res_ends_ff  <= res_ends_in;
      res_full_ff  <= res_full_in;
      if (load_out) begin
         rsp_node_ff <= NODE_OUT_W'(res_node_ff);
         rsp_ends_ff <= res_ends_ff;
         rsp_full_ff <= res_full_ff;
      end
   end

   // Child table
   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_waddr] <= child_wdata;
      end
      child_q <= child_mem[child_raddr];
   end

   // Suffix link table
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_q <= link_mem[link_raddr];
   end

   // Parent table
   always_ff @(posedge clock) begin
      if (parent_we) begin
         parent_mem[parent_waddr] <= parent_wdata;
      end
      parent_q <= parent_mem[parent_raddr];
   end

   // End counts; the root is never written and reads as zero
   always_ff @(posedge clock) begin
      if (ends_we) begin
         ends_mem[ends_waddr] <= ends_wdata;
      end
      ends_q       <= ends_mem[ends_raddr];
      ends_zero_ff <= (ends_raddr == '0);
   end

   // Breadth-first queue
   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[queue_waddr] <= queue_wdata;
      end
      queue_q <= queue_mem[queue_raddr];
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.node         = rsp_node_ff;
   assign rsp.pattern_ends = rsp_ends_ff;
   assign rsp.table_full   = rsp_full_ff;

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.idle     = (state_ff == ST_IDLE);

endmodule
